// File: hdl/adfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package adfs_pkg;

  // Walk stops taking bytes at this buffer position.
  localparam logic [7:0] MaxPacketBytes = 8'd255;

  // Structure type codes
  localparam logic [7:0] TypeUuidIncomplete = 8'h06;
  localparam logic [7:0] TypeUuidComplete   = 8'h07;
  localparam logic [7:0] TypeNameShort      = 8'h08;
  localparam logic [7:0] TypeNameComplete   = 8'h09;
  localparam logic [7:0] TypeMfr            = 8'hFF;

  localparam int unsigned UuidChunkBytes = 16;
  localparam int unsigned CompanyIdBytes = 2;

  // Offsets from structure start: length and type bytes, plus company id for mfr data
  localparam logic [7:0] NameSkip = 8'd2;
  localparam logic [7:0] MfrSkip  = 8'(2 + CompanyIdBytes);

  // Configuration register indexes
  localparam logic [1:0] RegUuidLow  = 2'd0;
  localparam logic [1:0] RegUuidHigh = 2'd1;
  localparam logic [1:0] RegNameMax  = 2'd2;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_PAYLOAD,
    PH_STOP
  } phase_e;

  typedef enum logic [1:0] {
    CL_OTHER,
    CL_MFR,
    CL_UUID,
    CL_NAME
  } class_e;

  typedef struct packed {
    logic [127:0] uuid;
    logic [7:0]   name_max_len;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  pos;
    phase_e      phase;
    logic [7:0]  start;
    logic [7:0]  left;
    class_e      cls;
    logic [7:0]  pidx;
    logic        chunk_eq;
    logic [15:0] company;
    logic        uuid_hit;
  } walk_t;

  typedef struct packed {
    logic        mfr_found;
    logic [15:0] company_id;
    logic [7:0]  mfr_data_offset;
    logic [7:0]  mfr_data_length;
    logic        uuid_found;
    logic        name_found;
    logic [7:0]  name_offset;
    logic [7:0]  name_length;
  } res_t;

  localparam walk_t WalkReset = '{
    pos: 8'd0, phase: PH_LEN, start: 8'd0, left: 8'd0, cls: CL_OTHER,
    pidx: 8'd0, chunk_eq: 1'b1, company: 16'd0, uuid_hit: 1'b0
  };

  localparam res_t ResReset = '0;

endpackage

`default_nettype wire

// File: hdl/adfs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module adfs_cfg
  import adfs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  output cfg_t             cfg_o
);

  logic [63:0] uuid_lo_q;
  logic [63:0] uuid_hi_q;
  logic [7:0]  name_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uuid_lo_q  <= '0;
      uuid_hi_q  <= '0;
      name_max_q <= 8'hFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegUuidLow:  uuid_lo_q  <= cfg_wdata_i;
        RegUuidHigh: uuid_hi_q  <= cfg_wdata_i;
        RegNameMax:  name_max_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.uuid         = {uuid_hi_q, uuid_lo_q};
  assign cfg_o.name_max_len = name_max_q;

endmodule

`default_nettype wire

// File: hdl/adfs_parse.sv
`timescale 1ns / 1ps
`default_nettype none

module adfs_parse
  import adfs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cfg_t       cfg_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       out_free_i,
  output logic            res_push_o,
  output res_t            res_o
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       advance;
  logic       load;

  walk_t      walk_q, walk_d;
  res_t       held_q, held_d;
  logic       fin;
  logic       eq;
  logic [7:0] tgt;
  logic [7:0] cap;

  // A last beat waits in the input register until the result slot frees up.
  assign advance    = in_valid_q && (!last_q || out_free_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (load) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign tgt = cfg_i.uuid[{walk_q.pidx[3:0], 3'b000} +: 8];
  assign cap = cfg_i.name_max_len - 8'd1;

  always_comb begin
    walk_d     = walk_q;
    held_d     = held_q;
    fin        = 1'b0;
    eq         = walk_q.chunk_eq && (byte_q == tgt);
    res_push_o = 1'b0;
    res_o      = held_q;
    if (advance) begin
      if (walk_q.pos < MaxPacketBytes) begin
        unique case (walk_q.phase)
          PH_LEN: begin
            if (byte_q == 8'd0) begin
              walk_d.phase = PH_STOP;
            end else begin
              walk_d.start = walk_q.pos;
              walk_d.left  = byte_q;
              walk_d.phase = PH_TYPE;
            end
          end
          PH_TYPE: begin
            unique case (byte_q) inside
              TypeMfr:                             walk_d.cls = CL_MFR;
              TypeUuidIncomplete, TypeUuidComplete: walk_d.cls = CL_UUID;
              TypeNameShort, TypeNameComplete:      walk_d.cls = CL_NAME;
              default:                             walk_d.cls = CL_OTHER;
            endcase
            walk_d.pidx     = 8'd0;
            walk_d.chunk_eq = 1'b1;
            walk_d.company  = 16'd0;
            walk_d.uuid_hit = 1'b0;
            walk_d.left     = walk_q.left - 8'd1;
            walk_d.phase    = PH_PAYLOAD;
            fin             = (walk_q.left == 8'd1);
          end
          PH_PAYLOAD: begin
            if (walk_q.pidx == 8'd0) begin
              walk_d.company = {8'd0, byte_q};
            end else if (walk_q.pidx == 8'd1) begin
              walk_d.company = {byte_q, walk_q.company[7:0]};
            end
            if (walk_q.pidx[3:0] == 4'(UuidChunkBytes - 1)) begin
              walk_d.uuid_hit = walk_q.uuid_hit | eq;
              walk_d.chunk_eq = 1'b1;
            end else begin
              walk_d.chunk_eq = eq;
            end
            walk_d.pidx = walk_q.pidx + 8'd1;
            walk_d.left = walk_q.left - 8'd1;
            fin         = (walk_q.left == 8'd1);
          end
          PH_STOP: ;
          default: ;
        endcase
      end

      if (fin) begin
        // first long-enough mfr structure, any uuid chunk hit, first name
        if (walk_d.cls == CL_MFR && !held_q.mfr_found &&
            walk_d.pidx >= 8'(CompanyIdBytes)) begin
          held_d.mfr_found       = 1'b1;
          held_d.company_id      = walk_d.company;
          held_d.mfr_data_offset = walk_d.start + MfrSkip;
          held_d.mfr_data_length = walk_d.pidx - 8'(CompanyIdBytes);
        end else if (walk_d.cls == CL_UUID && walk_d.uuid_hit) begin
          held_d.uuid_found = 1'b1;
        end else if (walk_d.cls == CL_NAME && !held_q.name_found &&
                     cfg_i.name_max_len != 8'd0) begin
          held_d.name_found  = 1'b1;
          held_d.name_offset = walk_d.start + NameSkip;
          held_d.name_length = (walk_d.pidx < cap) ? walk_d.pidx : cap;
        end
        walk_d.phase = PH_LEN;
      end

      if (walk_q.pos != 8'hFF) begin
        walk_d.pos = walk_q.pos + 8'd1;
      end

      if (last_q) begin
        res_push_o = 1'b1;
        res_o      = held_d;
        walk_d     = WalkReset;
        held_d     = ResReset;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= WalkReset;
      held_q <= ResReset;
    end else begin
      walk_q <= walk_d;
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/adfs_out.sv
`timescale 1ns / 1ps
`default_nettype none

module adfs_out
  import adfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic res_push_i,
  input  wire res_t res_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      res_o
);

  logic out_valid_q;
  res_t res_q;

  assign out_free_o  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push_i) begin
      out_valid_q <= 1'b1;
    end else if (out_free_o) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// File: hdl/adv_data_field_scanner.sv
// Channel   Dir  Handshake              Beat payload
// in        in   in_valid_i/in_stall_o   data_byte_i, last_byte_i
// out       out  out_valid_o/out_stall_i mfr/uuid/name summary fields
// cfg       in   cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// One beat per cycle unless in_stall_o holds a last beat; a byte goes input register -> walk state,
// and the summary goes into the output register once the last beat leaves the input register.
// Async active-low reset clears walk state and results; name_max_len resets to 255.
// in_stall_o rises only while a last beat waits on a full, stalled output register.
// No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module adv_data_field_scanner
  import adfs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             mfr_found_o,
  output logic [15:0]      company_id_o,
  output logic [7:0]       mfr_data_offset_o,
  output logic [7:0]       mfr_data_length_o,
  output logic             uuid_found_o,
  output logic             name_found_o,
  output logic [7:0]       name_offset_o,
  output logic [7:0]       name_length_o
);

  cfg_t cfg;
  res_t res_new;
  res_t res_out;
  logic res_push;
  logic out_free;

  adfs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  adfs_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .out_free_i  (out_free),
    .res_push_o  (res_push),
    .res_o       (res_new)
  );

  adfs_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_push_i  (res_push),
    .res_i       (res_new),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign mfr_found_o       = res_out.mfr_found;
  assign company_id_o      = res_out.company_id;
  assign mfr_data_offset_o = res_out.mfr_data_offset;
  assign mfr_data_length_o = res_out.mfr_data_length;
  assign uuid_found_o      = res_out.uuid_found;
  assign name_found_o      = res_out.name_found;
  assign name_offset_o     = res_out.name_offset;
  assign name_length_o     = res_out.name_length;

`ifndef ASSERT_OFF
  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output slot free");

  a_mfr_zero_when_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mfr_found_o) |->
      (company_id_o == 16'd0 && mfr_data_offset_o == 8'd0 && mfr_data_length_o == 8'd0))
    else $error("mfr fields nonzero without mfr structure");

  a_name_zero_when_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !name_found_o) |-> (name_offset_o == 8'd0 && name_length_o == 8'd0))
    else $error("name fields nonzero without name structure");

  a_name_len_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (name_length_o != 8'hFF && mfr_data_length_o <= 8'd252))
    else $error("length out of range");
`endif

endmodule

`default_nettype wire

// File: tb/adfs_checker.sv
`timescale 1ns / 1ps

module adfs_checker
  import adfs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  res_t             got_i,
  output int unsigned      mismatches_o,
  output int unsigned      results_due_o,
  output int unsigned      summaries_o,
  output int unsigned      mfr_hits_o,
  output int unsigned      uuid_hits_o,
  output int unsigned      name_hits_o
);

  // Shadow registers
  logic [127:0] target_uuid = '0;
  logic [7:0]   name_limit  = 8'd255;

  // Walk state and what has been found so far in the current packet
  walk_t walk  = WalkReset;
  res_t  found = ResReset;

  res_t summary_q[$];

  int unsigned mismatches = 0;
  int unsigned summaries  = 0;
  int unsigned mfr_hits   = 0;
  int unsigned uuid_hits  = 0;
  int unsigned name_hits  = 0;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Structure fully received: record it if it is the one we look for.
  task automatic close_structure();
    logic [7:0] cap;
    if (walk.cls == CL_MFR && !found.mfr_found && walk.pidx >= 8'(CompanyIdBytes)) begin
      found.mfr_found       = 1'b1;
      found.company_id      = walk.company;
      found.mfr_data_offset = walk.start + MfrSkip;
      found.mfr_data_length = walk.pidx - 8'(CompanyIdBytes);
    end else if (walk.cls == CL_UUID && walk.uuid_hit) begin
      found.uuid_found = 1'b1;
    end else if (walk.cls == CL_NAME && !found.name_found && name_limit != 8'd0) begin
      cap = name_limit - 8'd1;
      found.name_found  = 1'b1;
      found.name_offset = walk.start + NameSkip;
      found.name_length = (walk.pidx < cap) ? walk.pidx : cap;
    end
    walk.phase = PH_LEN;
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic [3:0] k;
    logic       eq;
    if (walk.pos < MaxPacketBytes) begin
      case (walk.phase)
        PH_LEN: begin
          if (b == 8'd0) begin
            walk.phase = PH_STOP;
          end else begin
            walk.start = walk.pos;
            walk.left  = b;
            walk.phase = PH_TYPE;
          end
        end
        PH_TYPE: begin
          if (b == TypeMfr) walk.cls = CL_MFR;
          else if (b == TypeUuidIncomplete || b == TypeUuidComplete) walk.cls = CL_UUID;
          else if (b == TypeNameShort || b == TypeNameComplete) walk.cls = CL_NAME;
          else walk.cls = CL_OTHER;
          walk.pidx     = 8'd0;
          walk.chunk_eq = 1'b1;
          walk.company  = 16'd0;
          walk.uuid_hit = 1'b0;
          walk.left     = walk.left - 8'd1;
          if (walk.left == 8'd0) close_structure();
          else walk.phase = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (walk.pidx == 8'd0) walk.company = {8'h00, b};
          else if (walk.pidx == 8'd1) walk.company[15:8] = b;
          // compare against the target a 16-byte chunk at a time
          k  = walk.pidx[3:0];
          eq = walk.chunk_eq && (b == target_uuid[8*k +: 8]);
          if (k == 4'(UuidChunkBytes - 1)) begin
            if (eq) walk.uuid_hit = 1'b1;
            walk.chunk_eq = 1'b1;
          end else begin
            walk.chunk_eq = eq;
          end
          walk.pidx = walk.pidx + 8'd1;
          walk.left = walk.left - 8'd1;
          if (walk.left == 8'd0) close_structure();
        end
        default: ;
      endcase
    end
    if (walk.pos != 8'hFF) walk.pos = walk.pos + 8'd1;
    if (last) begin
      summary_q.push_back(found);
      mfr_hits  += found.mfr_found;
      uuid_hits += found.uuid_found;
      name_hits += found.name_found;
      walk  = WalkReset;
      found = ResReset;
    end
  endtask

  task automatic check_summary();
    res_t want;
    if (summary_q.size() == 0) begin
      report_mismatch("summary beat with none pending", 1, 0);
      return;
    end
    want = summary_q.pop_front();
    summaries++;
    if (got_i.mfr_found != want.mfr_found)
      report_mismatch("mfr_found", got_i.mfr_found, want.mfr_found);
    if (got_i.company_id != want.company_id)
      report_mismatch("company_id", got_i.company_id, want.company_id);
    if (got_i.mfr_data_offset != want.mfr_data_offset)
      report_mismatch("mfr_data_offset", got_i.mfr_data_offset, want.mfr_data_offset);
    if (got_i.mfr_data_length != want.mfr_data_length)
      report_mismatch("mfr_data_length", got_i.mfr_data_length, want.mfr_data_length);
    if (got_i.uuid_found != want.uuid_found)
      report_mismatch("uuid_found", got_i.uuid_found, want.uuid_found);
    if (got_i.name_found != want.name_found)
      report_mismatch("name_found", got_i.name_found, want.name_found);
    if (got_i.name_offset != want.name_offset)
      report_mismatch("name_offset", got_i.name_offset, want.name_offset);
    if (got_i.name_length != want.name_length)
      report_mismatch("name_length", got_i.name_length, want.name_length);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_uuid = '0;
      name_limit  = 8'd255;
      walk        = WalkReset;
      found       = ResReset;
      summary_q.delete();
    end else begin
      // the summary beat always belongs to an older packet, so pop first
      if (out_valid_i && !out_stall_i) check_summary();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegUuidLow:  target_uuid[63:0]   = cfg_wdata_i;
          RegUuidHigh: target_uuid[127:64] = cfg_wdata_i;
          RegNameMax:  name_limit          = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) scan_byte(data_byte_i, last_byte_i);
    end
    mismatches_o  <= mismatches;
    results_due_o <= summary_q.size();
    summaries_o   <= summaries;
    mfr_hits_o    <= mfr_hits;
    uuid_hits_o   <= uuid_hits;
    name_hits_o   <= name_hits;
  end

endmodule

// File: tb/tb_adv_data_field_scanner.sv
`timescale 1ns / 1ps

module tb_adv_data_field_scanner;
  import adfs_pkg::*;

  localparam int unsigned IdleLimit     = 4000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned PhaseBytes    = 95;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = RegUuidLow;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = 8'd0;
  logic        last_byte_i = 1'b0;
  logic        out_stall_i = 1'b0;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        mfr_found_o;
  logic [15:0] company_id_o;
  logic [7:0]  mfr_data_offset_o;
  logic [7:0]  mfr_data_length_o;
  logic        uuid_found_o;
  logic        name_found_o;
  logic [7:0]  name_offset_o;
  logic [7:0]  name_length_o;

  int unsigned mismatches;
  int unsigned results_due;
  int unsigned summaries;
  int unsigned mfr_hits;
  int unsigned uuid_hits;
  int unsigned name_hits;

  bit           calm         = 1'b0;
  int unsigned  holdoff_req  = 0;
  int unsigned  holdoff_left = 0;
  int unsigned  quiet        = 0;
  int unsigned  bytes_sent   = 0;
  int unsigned  packets_sent = 0;
  int unsigned  settings     = 1;
  logic [127:0] uuid_target  = '0;
  logic [7:0]   pkt[$];

  // {last, byte}: null packet, lone length byte, short then full mfr structure,
  // empty name followed by a stop and junk, a two-character name
  logic [8:0] opening [18] = '{
    {1'b1, 8'h00},
    {1'b1, 8'hFF},
    {1'b0, 8'h02}, {1'b0, TypeMfr}, {1'b0, 8'hAA},
    {1'b0, 8'h04}, {1'b0, TypeMfr}, {1'b0, 8'h34}, {1'b0, 8'h12}, {1'b1, 8'h56},
    {1'b0, 8'h01}, {1'b0, TypeNameShort}, {1'b0, 8'h00}, {1'b1, 8'hEE},
    {1'b0, 8'h03}, {1'b0, TypeNameComplete}, {1'b0, 8'h41}, {1'b1, 8'h42}
  };

  adv_data_field_scanner u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .mfr_found_o       (mfr_found_o),
    .company_id_o      (company_id_o),
    .mfr_data_offset_o (mfr_data_offset_o),
    .mfr_data_length_o (mfr_data_length_o),
    .uuid_found_o      (uuid_found_o),
    .name_found_o      (name_found_o),
    .name_offset_o     (name_offset_o),
    .name_length_o     (name_length_o)
  );

  adfs_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .got_i         ({mfr_found_o, company_id_o, mfr_data_offset_o, mfr_data_length_o,
                     uuid_found_o, name_found_o, name_offset_o, name_length_o}),
    .mismatches_o  (mismatches),
    .results_due_o (results_due),
    .summaries_o   (summaries),
    .mfr_hits_o    (mfr_hits),
    .uuid_hits_o   (uuid_hits),
    .name_hits_o   (name_hits)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left != 0) begin
      out_stall_i <= 1'b1;
      holdoff_left--;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 17);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == IdleLimit) begin
        $display("no beat accepted for %0d cycles", IdleLimit);
        $display("** adv_data_field_scanner: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    if (last) packets_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == pkt.size() - 1);
  endtask

  // Drop valid and let every pending summary drain out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [7:0] limit);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegUuidLow;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= RegUuidHigh;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    // junk above bit 7 must be ignored
    cfg_idx_i   <= RegNameMax;
    cfg_wdata_i <= {32'($urandom), 24'($urandom), limit};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    uuid_target = {hi, lo};
    settings++;
  endtask

  task automatic add_structure(input logic [7:0] kind, input int plen);
    int         mode;
    int         spoil;
    logic [7:0] b;
    pkt.push_back(8'(plen + 1));
    pkt.push_back(kind);
    for (int i = 0; i < plen; i++) begin
      if (kind == TypeUuidComplete || kind == TypeUuidIncomplete) begin
        // per chunk: exact target, target with one byte off, or random
        if (i % 16 == 0) begin
          mode  = $urandom_range(3);
          spoil = $urandom_range(15);
        end
        b = uuid_target[8*(i%16) +: 8];
        if (mode == 2 && i % 16 == spoil) b = b ^ 8'($urandom_range(1, 255));
        else if (mode == 3) b = 8'($urandom);
      end else begin
        b = 8'($urandom);
      end
      pkt.push_back(b);
    end
  endtask

  task automatic add_random_structure(input bit allow_stop);
    int pick;
    int uuid_len;
    pick     = $urandom_range(99);
    uuid_len = 16 * $urandom_range(0, 2) + (($urandom_range(3) == 0) ? $urandom_range(1, 15) : 0);
    if (pick < 25) begin
      add_structure(TypeMfr, $urandom_range(0, 6));
    end else if (pick < 45) begin
      add_structure($urandom_range(1) ? TypeUuidComplete : TypeUuidIncomplete, uuid_len);
    end else if (pick < 65) begin
      add_structure($urandom_range(1) ? TypeNameComplete : TypeNameShort, $urandom_range(0, 8));
    end else if (pick < 90 || !allow_stop) begin
      add_structure(8'($urandom), $urandom_range(0, 5));
    end else begin
      pkt.push_back(8'h00);
      repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
    end
  endtask

  // Mostly well-formed packets; some cut short, some pure noise.
  task automatic build_random_packet();
    int shape;
    pkt.delete();
    shape = $urandom_range(99);
    if (shape < 15) begin
      repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 4)) add_random_structure(1'b1);
    if (shape < 30 && pkt.size() > 1) repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
    if (pkt.size() == 0) pkt.push_back(8'($urandom));
  endtask

  // Long packet that can run past the end of the walk window.
  task automatic build_long_packet();
    int goal;
    pkt.delete();
    goal = $urandom_range(240, 300);
    while (pkt.size() < goal) add_random_structure(1'b0);
    while (pkt.size() > goal) void'(pkt.pop_back());
  endtask

  initial begin
    int unsigned goal;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening[i]) send_beat(opening[i][7:0], opening[i][8]);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) begin
        wait_drained();
        case (ph)
          1: program_regs('0, '0, 8'd0);
          2: program_regs('1, '1, 8'd1);
          3: program_regs({$urandom, $urandom}, {$urandom, $urandom}, 8'd2);
          4: program_regs({$urandom, $urandom}, {$urandom, $urandom}, 8'd255);
          5: program_regs({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
          6: program_regs({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom_range(3, 10)));
          default: program_regs({$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
        endcase
      end
      calm = (ph == 3);
      // receiver holds off while packets keep coming, so the input backs up
      if (ph == 5) holdoff_req = HoldOffCycles;
      if (ph == 4 || ph == 7) begin
        build_long_packet();
        send_packet();
      end
      goal = bytes_sent + PhaseBytes;
      while (bytes_sent < goal) begin
        build_random_packet();
        send_packet();
        if ($urandom_range(99) < 4) wait_drained();
      end
    end
    calm = 1'b0;
    wait_drained();

    $display("%0d bytes in %0d packets, %0d summaries checked under %0d register settings;",
             bytes_sent, packets_sent, summaries, settings);
    $display("found: %0d manufacturer, %0d UUID, %0d name", mfr_hits, uuid_hits, name_hits);
    if (mismatches == 0 && results_due == 0) begin
      $display("** adv_data_field_scanner: PASSED **");
    end else begin
      $display("** adv_data_field_scanner: FAILED **");
    end
    $finish;
  end

endmodule
